FILE: hdl/tsq_pkg.sv
`default_nettype none
package tsq_pkg;

   // Table geometry and field widths
   localparam int SLOTS         = 6;
   localparam int TIME_BITS     = 16;
   localparam int TASK_BITS     = 8;
   localparam int SLOT_IDX_BITS = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_MIN_BITS  = $clog2(SLOTS + 1);
   localparam int CNT_BITS      = (CNT_MIN_BITS > 3) ? CNT_MIN_BITS : 3;
   localparam int OCC_BITS      = 3;

   // Command codes
   localparam logic CMD_PUSH  = 1'b0;
   localparam logic CMD_CHECK = 1'b1;

   typedef logic [TIME_BITS-1:0]     time_type;
   typedef logic [TASK_BITS-1:0]     task_type;
   typedef logic [SLOT_IDX_BITS-1:0] slot_idx_type;
   typedef logic [CNT_BITS-1:0]      cnt_type;

   // Operation handed to the slot table
   typedef struct packed {
      logic     valid;
      logic     cmd;
      time_type now;
      time_type due;
      task_type task_id;
   } tsq_op_type;

   // Outcome reported by the slot table
   typedef struct packed {
      logic     placed;
      logic     dropped;
      logic     fired;
      task_type fired_task;
   } tsq_status_type;

   // Due time: wrapped sum, plus one on wrap, never zero
   function automatic time_type make_due(time_type now, time_type offset);
      logic [TIME_BITS:0] sum;
      time_type           due;
      sum = {1'b0, now} + {1'b0, offset};
      due = sum[TIME_BITS-1:0] + time_type'(sum[TIME_BITS]);
      if (due == '0) begin
         due = time_type'(1);
      end
      return due;
   endfunction

endpackage
`default_nettype wire

FILE: hdl/tsq_slot_table.sv
`default_nettype none
module tsq_slot_table
   import tsq_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire tsq_op_type     op,
   output      tsq_status_type status
);

   time_type     due_ff  [SLOTS];
   task_type     task_ff [SLOTS];

   logic         free_found;
   slot_idx_type free_idx;
   logic         match_found;
   slot_idx_type match_idx;
   logic         do_push;
   logic         do_fire;

   // Find the lowest free slot and the lowest due slot
   always_comb begin
      free_found  = 1'b0;
      free_idx    = '0;
      match_found = 1'b0;
      match_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (due_ff[i] == '0) begin
            free_found = 1'b1;
            free_idx   = slot_idx_type'(i);
         end
         if (due_ff[i] != '0 && due_ff[i] == op.now) begin
            match_found = 1'b1;
            match_idx   = slot_idx_type'(i);
         end
      end
   end

   assign do_push = op.valid && op.cmd == CMD_PUSH && free_found;
   assign do_fire = op.valid && op.cmd == CMD_CHECK && match_found;

   // Report the outcome of this request
   always_comb begin
      status.placed     = do_push;
      status.dropped    = op.valid && op.cmd == CMD_PUSH && !free_found;
      status.fired      = do_fire;
      status.fired_task = do_fire ? task_ff[match_idx] : '0;
   end

   // Occupy on push, free on fire
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            due_ff[i] <= '0;
         end
      end else if (do_push) begin
         due_ff[free_idx] <= op.due;
      end else if (do_fire) begin
         due_ff[match_idx] <= '0;
      end
   end

   // Task ids are written with the push and need no reset
   always_ff @(posedge clock) begin
      if (do_push) begin
         task_ff[free_idx] <= op.task_id;
      end
   end

   a_push_fire_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(do_push && do_fire))
      else $error("push and fire in one request");

   a_push_fills_slot: assert property (@(posedge clock) disable iff (reset)
      do_push |=> due_ff[$past(free_idx)] != '0)
      else $error("pushed slot still reads free");

   a_fire_frees_slot: assert property (@(posedge clock) disable iff (reset)
      do_fire |=> due_ff[$past(match_idx)] == '0)
      else $error("fired slot not freed");

endmodule
`default_nettype wire

FILE: hdl/timed_task_slot_queue_top.sv
// Timed task slot queue: a small table of tasks, each waiting for its due time.
// Request channel (req_valid / req_stall): req_cmd selects push or check; every
// request carries the current time in req_now_time. A push stores req_task_id
// in the lowest free slot, due at now plus req_delay_offset; a full table drops
// the push and flags it. A check fires the lowest slot due at now, returns its
// task id and frees the slot.
// Response channel (rsp_valid / rsp_stall): one response per request, with the
// fired flag and task, the drop flag, and the current and peak occupancy.
// A request passes the input register, then the result register, before
// rsp_valid. Throughput: one request per cycle while responses are taken, set
// by the combinational compare and priority pick across all slots in the table.
// A stalled response holds in the result register; the request in the input
// register then waits and req_stall rises until the response is taken.
// Reset clears every slot, both counts and both valid flags.
`default_nettype none
module timed_task_slot_queue_top
   import tsq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output      logic                 req_stall,
   input  wire logic                 req_cmd,
   input  wire logic [TIME_BITS-1:0] req_now_time,
   input  wire logic [TIME_BITS-1:0] req_delay_offset,
   input  wire logic [TASK_BITS-1:0] req_task_id,
   output      logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   output      logic                 rsp_fired,
   output      logic [TASK_BITS-1:0] rsp_fired_task,
   output      logic                 rsp_push_dropped,
   output      logic [OCC_BITS-1:0]  rsp_occupancy,
   output      logic [OCC_BITS-1:0]  rsp_peak_occupancy
);

   logic           in_valid_ff;
   logic           in_cmd_ff;
   time_type       in_now_ff;
   time_type       in_offset_ff;
   task_type       in_task_ff;

   logic           out_valid_ff;
   logic           out_fired_ff;
   task_type       out_task_ff;
   logic           out_dropped_ff;
   logic [OCC_BITS-1:0] out_occ_ff;
   logic [OCC_BITS-1:0] out_peak_ff;

   cnt_type        count_ff;
   cnt_type        count_in;
   cnt_type        peak_ff;
   cnt_type        peak_in;

   logic           out_free;
   logic           advance;
   logic           accept;
   tsq_op_type     op;
   tsq_status_type status;

   // Advance when the result register is empty or being drained
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign advance   = in_valid_ff && out_free;
   assign req_stall = in_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // Hold the accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (accept) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff    <= req_cmd;
         in_now_ff    <= req_now_time;
         in_offset_ff <= req_delay_offset;
         in_task_ff   <= req_task_id;
      end
   end

   // Build the table operation
   always_comb begin
      op.valid   = advance;
      op.cmd     = in_cmd_ff;
      op.now     = in_now_ff;
      op.due     = make_due(in_now_ff, in_offset_ff);
      op.task_id = in_task_ff;
   end

   tsq_slot_table u_slot_table (
      .clock  (clock),
      .reset  (reset),
      .op     (op),
      .status (status)
   );

   // Advance occupancy and track its peak
   always_comb begin
      count_in = count_ff + cnt_type'(status.placed) - cnt_type'(status.fired);
      peak_in  = (count_in > peak_ff) ? count_in : peak_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         peak_ff  <= '0;
      end else if (advance) begin
         count_ff <= count_in;
         peak_ff  <= peak_in;
      end
   end

   // Hold the response until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_fired_ff   <= status.fired;
         out_task_ff    <= status.fired_task;
         out_dropped_ff <= status.dropped;
         out_occ_ff     <= count_in[OCC_BITS-1:0];
         out_peak_ff    <= peak_in[OCC_BITS-1:0];
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_fired          = out_fired_ff;
   assign rsp_fired_task     = out_task_ff;
   assign rsp_push_dropped   = out_dropped_ff;
   assign rsp_occupancy      = out_occ_ff;
   assign rsp_peak_occupancy = out_peak_ff;

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cnt_type'(SLOTS))
      else $error("occupancy beyond table size");

   a_peak_covers_count: assert property (@(posedge clock) disable iff (reset)
      peak_ff >= count_ff)
      else $error("peak below occupancy");

   a_fire_drops_count: assert property (@(posedge clock) disable iff (reset)
      advance && status.fired |=> count_ff == $past(count_ff) - cnt_type'(1))
      else $error("fire did not lower occupancy");

   a_drop_only_when_full: assert property (@(posedge clock) disable iff (reset)
      advance && status.dropped |-> count_ff == cnt_type'(SLOTS))
      else $error("push dropped with a free slot");

endmodule
`default_nettype wire

FILE: sim/timed_task_slot_queue_checker.sv
module timed_task_slot_queue_checker
   import tsq_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   input  wire logic                 req_stall,
   input  wire logic                 req_cmd,
   input  wire logic [TIME_BITS-1:0] req_now_time,
   input  wire logic [TIME_BITS-1:0] req_delay_offset,
   input  wire logic [TASK_BITS-1:0] req_task_id,
   input  wire logic                 rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire logic                 rsp_fired,
   input  wire logic [TASK_BITS-1:0] rsp_fired_task,
   input  wire logic                 rsp_push_dropped,
   input  wire logic [OCC_BITS-1:0]  rsp_occupancy,
   input  wire logic [OCC_BITS-1:0]  rsp_peak_occupancy,
   output int                        mismatch_count,
   output int                        pending_count,
   output int                        request_count,
   output int                        fire_count,
   output int                        drop_count
);

   typedef struct packed {
      logic                fired;
      task_type            fired_task;
      logic                dropped;
      logic [OCC_BITS-1:0] occupancy;
      logic [OCC_BITS-1:0] peak;
   } slot_result_type;

   // Shadow copy of the slot table
   time_type        due_tbl [SLOTS];
   task_type        task_tbl [SLOTS];
   int              used_slots;
   int              peak_slots;
   slot_result_type expected_results [$];

   // Running totals, zero at start of simulation
   int mismatch_total;
   int requests_seen;
   int fires_seen;
   int drops_seen;

   // Apply one request to the shadow table and return the response it should give
   function automatic slot_result_type schedule_or_fire(logic cmd, time_type now,
                                                        time_type offset, task_type id);
      slot_result_type    res;
      logic [TIME_BITS:0] sum;
      time_type           due;
      logic               done;
      int                 s;
      res  = '0;
      done = 1'b0;
      if (cmd == CMD_PUSH) begin
         // wrapped sum gains one; a zero due time is bumped to one
         sum = {1'b0, now} + {1'b0, offset};
         due = sum[TIME_BITS-1:0];
         if (sum[TIME_BITS]) begin
            due = due + time_type'(1);
         end
         if (due == '0) begin
            due = time_type'(1);
         end
         for (s = 0; s < SLOTS; s++) begin
            if (!done && due_tbl[s] == '0) begin
               due_tbl[s]  = due;
               task_tbl[s] = id;
               used_slots++;
               done = 1'b1;
            end
         end
         res.dropped = !done;
         if (used_slots > peak_slots) begin
            peak_slots = used_slots;
         end
      end else begin
         // lowest occupied slot due now fires, at most one
         for (s = 0; s < SLOTS; s++) begin
            if (!done && due_tbl[s] != '0 && due_tbl[s] == now) begin
               res.fired      = 1'b1;
               res.fired_task = task_tbl[s];
               due_tbl[s]     = '0;
               if (used_slots > 0) begin
                  used_slots--;
               end
               done = 1'b1;
            end
         end
      end
      res.occupancy = used_slots[OCC_BITS-1:0];
      res.peak      = peak_slots[OCC_BITS-1:0];
      return res;
   endfunction

   task automatic compare_field(input string field, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
         mismatch_total++;
      end
   endtask

   // Score responses against the oldest prediction, then predict new requests
   always @(posedge clock) begin
      slot_result_type want;
      if (reset) begin
         foreach (due_tbl[s]) begin
            due_tbl[s]  = '0;
            task_tbl[s] = '0;
         end
         used_slots = 0;
         peak_slots = 0;
         expected_results.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_results.size() == 0) begin
               $display("%0t: response with no request outstanding, expected none, actual %0h",
                        $time, {rsp_fired, rsp_fired_task, rsp_push_dropped, rsp_occupancy,
                                rsp_peak_occupancy});
               mismatch_total++;
            end else begin
               want = expected_results.pop_front();
               compare_field("fired", 16'(want.fired), 16'(rsp_fired));
               compare_field("fired_task", 16'(want.fired_task), 16'(rsp_fired_task));
               compare_field("push_dropped", 16'(want.dropped), 16'(rsp_push_dropped));
               compare_field("occupancy", 16'(want.occupancy), 16'(rsp_occupancy));
               compare_field("peak_occupancy", 16'(want.peak), 16'(rsp_peak_occupancy));
               fires_seen += want.fired;
               drops_seen += want.dropped;
            end
         end
         if (req_valid && !req_stall) begin
            expected_results.push_back(schedule_or_fire(req_cmd, req_now_time,
                                                        req_delay_offset, req_task_id));
            requests_seen++;
         end
      end
      mismatch_count <= mismatch_total;
      pending_count  <= expected_results.size();
      request_count  <= requests_seen;
      fire_count     <= fires_seen;
      drop_count     <= drops_seen;
   end

   // Flag anything still outstanding when the run stops
   final begin
      if (expected_results.size() != 0) begin
         $display("%0t: %0d responses outstanding, expected 0, actual %0d", $time,
                  expected_results.size(), expected_results.size());
      end
   end

endmodule

FILE: sim/tb_timed_task_slot_queue_top.sv
module tb_timed_task_slot_queue_top;
   import tsq_pkg::*;

   localparam int RANDOM_REQUESTS = 1800;
   localparam int QUIET_FROM      = 1600;
   localparam int LONG_HOLD       = 48;
   localparam int CYCLE_LIMIT     = 200000;
   localparam time_type HIGH_WINDOW = 16'hFFE8;

   logic                 clock            = 1'b0;
   logic                 reset            = 1'b1;
   logic                 req_valid        = 1'b0;
   logic                 req_stall;
   logic                 req_cmd          = CMD_PUSH;
   logic [TIME_BITS-1:0] req_now_time     = '0;
   logic [TIME_BITS-1:0] req_delay_offset = '0;
   logic [TASK_BITS-1:0] req_task_id      = '0;
   logic                 rsp_valid;
   logic                 rsp_stall        = 1'b0;
   logic                 rsp_fired;
   logic [TASK_BITS-1:0] rsp_fired_task;
   logic                 rsp_push_dropped;
   logic [OCC_BITS-1:0]  rsp_occupancy;
   logic [OCC_BITS-1:0]  rsp_peak_occupancy;

   int mismatch_count;
   int pending_count;
   int request_count;
   int fire_count;
   int drop_count;
   int cycle_count = 0;

   bit quiet_mode        = 1'b0;
   bit long_hold_request = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   timed_task_slot_queue_top dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_now_time       (req_now_time),
      .req_delay_offset   (req_delay_offset),
      .req_task_id        (req_task_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fired          (rsp_fired),
      .rsp_fired_task     (rsp_fired_task),
      .rsp_push_dropped   (rsp_push_dropped),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_peak_occupancy (rsp_peak_occupancy)
   );

   timed_task_slot_queue_checker queue_check (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_cmd            (req_cmd),
      .req_now_time       (req_now_time),
      .req_delay_offset   (req_delay_offset),
      .req_task_id        (req_task_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_fired          (rsp_fired),
      .rsp_fired_task     (rsp_fired_task),
      .rsp_push_dropped   (rsp_push_dropped),
      .rsp_occupancy      (rsp_occupancy),
      .rsp_peak_occupancy (rsp_peak_occupancy),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .request_count      (request_count),
      .fire_count         (fire_count),
      .drop_count         (drop_count)
   );

   // Stop a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end
   end

   // Response side: random stall bursts, one long hold on request
   initial begin
      bit long_hold_done;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_request && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (LONG_HOLD) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (!quiet_mode && $urandom_range(0, 7) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one request and hold it until it is taken
   task automatic send_request(input logic cmd, input time_type now, input time_type offset,
                               input task_type id);
      req_valid        <= 1'b1;
      req_cmd          <= cmd;
      req_now_time     <= now;
      req_delay_offset <= offset;
      req_task_id      <= id;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic idle_sender(input int cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   initial begin
      time_type window_base;
      time_type due_pick;
      time_type now_pick;
      int       pick;
      bit       bursty;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Fill the table through the corner due times, overflow it, then fire each slot
      send_request(CMD_PUSH,  16'h0000, 16'h0000, 8'h01);
      send_request(CMD_PUSH,  16'hFFFF, 16'h0001, 8'h02);
      send_request(CMD_PUSH,  16'hFFFF, 16'hFFFF, 8'hFF);
      send_request(CMD_PUSH,  16'h0000, 16'hFFFF, 8'h00);
      send_request(CMD_PUSH,  16'h0100, 16'h0005, 8'hA5);
      send_request(CMD_PUSH,  16'h8000, 16'h8000, 8'h5A);
      send_request(CMD_PUSH,  16'h0007, 16'h0007, 8'h3C);
      send_request(CMD_CHECK, 16'h0000, 16'hFFFF, 8'hFF);
      send_request(CMD_CHECK, 16'h0001, 16'h0000, 8'h00);
      send_request(CMD_CHECK, 16'h0001, 16'h1234, 8'h99);
      send_request(CMD_CHECK, 16'hFFFF, 16'h0000, 8'h00);
      send_request(CMD_PUSH,  16'h0002, 16'h0003, 8'h77);
      send_request(CMD_CHECK, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_request(CMD_CHECK, 16'hFFFF, 16'h0000, 8'h00);
      send_request(CMD_CHECK, 16'h0105, 16'hAAAA, 8'h55);
      send_request(CMD_CHECK, 16'h0001, 16'h5555, 8'hAA);
      send_request(CMD_CHECK, 16'h0005, 16'h0000, 8'h00);
      send_request(CMD_CHECK, 16'h0001, 16'h0000, 8'h00);
      drain_responses();

      // Random traffic: due times kept inside one of two windows so slots keep draining
      window_base = '0;
      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if (n % 64 == 0) begin
            window_base = ($urandom_range(0, 1) == 0) ? time_type'(0) : HIGH_WINDOW;
         end
         if (n == 500) begin
            long_hold_request = 1'b1;
         end
         if (n == 1000) begin
            drain_responses();
         end
         if (n == QUIET_FROM) begin
            quiet_mode = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 10) begin
            send_request(CMD_CHECK, time_type'($urandom), time_type'($urandom),
                         task_type'($urandom));
         end else if (pick < 57) begin
            due_pick = window_base + time_type'($urandom_range(0, 23));
            now_pick = ($urandom_range(0, 9) == 0) ? due_pick : time_type'($urandom);
            send_request(CMD_PUSH, now_pick, due_pick - now_pick, task_type'($urandom));
         end else begin
            send_request(CMD_CHECK, window_base + time_type'($urandom_range(0, 25)),
                         time_type'($urandom), task_type'($urandom));
         end
         // sender gaps, with every third stretch left without them
         bursty = ((n / 100) % 3) != 2;
         if (!quiet_mode && bursty && $urandom_range(0, 7) == 0) begin
            idle_sender($urandom_range(1, 6));
         end
      end

      // Let the last responses out, then give the verdict
      drain_responses();
      repeat (4) @(posedge clock);
      $display("Ran %0d requests: %0d tasks fired, %0d pushes dropped on a full table,",
               request_count, fire_count, drop_count);
      $display("with wrap and zero due times, a long response hold and a full drain.");
      if (mismatch_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
